### design/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_NR(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ctfti_pkg.sv
package ctfti_pkg;

  localparam int QUANTITIES = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_VALUE_BITS = 6;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_INTERP = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_SIZE_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_SIZE_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_SIZE_Z = 3'd5;

  typedef struct packed {
    logic               kind;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [5:0]         pos_z;
    logic signed [31:0] density_in;
    logic signed [31:0] velocity_x_in;
    logic signed [31:0] velocity_y_in;
    logic signed [31:0] velocity_z_in;
  } item_word_t;

  typedef struct packed {
    logic signed [31:0] density_out;
    logic signed [31:0] velocity_x_out;
    logic signed [31:0] velocity_y_out;
    logic signed [31:0] velocity_z_out;
  } result_word_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_VALUE_BITS-1:0] value;
  } cfg_word_t;

  // bit set = axis uses its 3/4 weight; product over axes is 3^ones
  function automatic logic [4:0] neighbor_weight(input logic [2:0] heavy);
    logic [4:0] w;
    unique case (heavy)
      3'b000:                 w = 5'd1;
      3'b001, 3'b010, 3'b100: w = 5'd3;
      3'b011, 3'b101, 3'b110: w = 5'd9;
      3'b111:                 w = 5'd27;
      default:                w = 5'd1;
    endcase
    return w;
  endfunction

endpackage

### design/ctfti_chan.sv
interface ctfti_chan #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### design/ctfti_ram.sv
module ctfti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/ctfti_addr.sv
// cell address x + (y + z*sy)*sx, two registered multiply-add steps
module ctfti_addr #(
  parameter int COARSE_DIM_MAX = 32
) (
  input  logic                                               clk,
  input  logic [$clog2(COARSE_DIM_MAX)-1:0]                  x,
  input  logic [$clog2(COARSE_DIM_MAX)-1:0]                  y,
  input  logic [$clog2(COARSE_DIM_MAX)-1:0]                  z,
  input  logic [$clog2(COARSE_DIM_MAX+1)-1:0]                sx,
  input  logic [$clog2(COARSE_DIM_MAX+1)-1:0]                sy,
  output logic [$clog2(COARSE_DIM_MAX*COARSE_DIM_MAX*COARSE_DIM_MAX)-1:0] addr
);
  localparam int CW = $clog2(COARSE_DIM_MAX);
  localparam int SW = $clog2(COARSE_DIM_MAX + 1);
  localparam int TW = $clog2(COARSE_DIM_MAX * COARSE_DIM_MAX);
  localparam int AW = $clog2(COARSE_DIM_MAX * COARSE_DIM_MAX * COARSE_DIM_MAX);
  localparam int PW1 = CW + SW;
  localparam int PW2 = TW + SW;

  logic [PW1-1:0] plane;
  logic [PW2-1:0] lin;
  logic [TW-1:0]  row;
  logic [CW-1:0]  x_d;

  assign plane = PW1'(z) * PW1'(sy) + PW1'(y);
  assign lin   = PW2'(row) * PW2'(sx) + PW2'(x_d);

  always_ff @(posedge clk) begin
    row  <= TW'(plane);
    x_d  <= x;
    addr <= AW'(lin);
  end
endmodule

### design/ctfti_mac.sv
// four weighted-sum lanes with (sum + 32) >>> 6 rounding
module ctfti_mac #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         clear,
  input  logic                                         en,
  input  logic [4:0]                                   weight,
  input  logic [ctfti_pkg::QUANTITIES-1:0][VALUE_BITS-1:0] rdata,
  output logic [ctfti_pkg::QUANTITIES-1:0][VALUE_BITS-1:0] rounded
);
  import ctfti_pkg::*;

  localparam int ACCW = VALUE_BITS + 7;
  localparam int PW   = VALUE_BITS + 6;

  logic signed [ACCW-1:0] acc [QUANTITIES];

  for (genvar q = 0; q < QUANTITIES; q++) begin : g_lane
    logic signed [PW-1:0]   prod;
    logic signed [ACCW-1:0] biased;

    assign prod   = $signed(rdata[q]) * $signed({1'b0, weight});
    assign biased = acc[q] + ACCW'(32);
    assign rounded[q] = VALUE_BITS'(biased >>> 6);

    always_ff @(posedge clk) begin
      if (clear) begin
        acc[q] <= '0;
      end else if (en) begin
        acc[q] <= acc[q] + ACCW'(prod);
      end
    end
  end
endmodule

### design/coarse_to_fine_trilinear_interp.sv
// Trilinear coarse-to-fine interpolation over a stored coarse field of density and three
// velocity components. A write word (kind 0) stores one coarse cell before item.ready
// returns; writes outside the configured grid are dropped in the setup state. An
// interpolate word (kind 1) passes a setup state that clamps the lower and upper
// neighbor coordinates per axis, eight neighbor reads issued through the shared address
// multiply-add unit into the single-port cell memories (one neighbor per cycle, address
// and read data registered), and a rounding state into the output register. The reads
// all go through the one memory port. A finished result waits in its output register
// while the next word is taken; a second result holds the rounding state until the
// first one is taken. Configuration may be written at any time the block is idle;
// cfg.ready is always high.
module coarse_to_fine_trilinear_interp #(
  parameter int COARSE_DIM_MAX = 32,
  parameter int VALUE_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  ctfti_chan.sink   item,
  ctfti_chan.source result,
  ctfti_chan.sink   cfg
);
  import ctfti_pkg::*;

  localparam int CW         = $clog2(COARSE_DIM_MAX);
  localparam int SW         = $clog2(COARSE_DIM_MAX + 1);
  localparam int DEPTH      = COARSE_DIM_MAX * COARSE_DIM_MAX * COARSE_DIM_MAX;
  localparam int AW         = $clog2(DEPTH);
  localparam int NEIGHBORS  = 8;
  localparam int READ_LAT   = 3;
  localparam int WRITE_STEP = 2;
  localparam int LAST_STEP  = NEIGHBORS - 1 + READ_LAT;
  localparam int STW        = $clog2(LAST_STEP + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PREP  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  logic [1:0]     state, state_next;
  logic [STW-1:0] step;

  logic [4:0] origin_x, origin_y, origin_z;
  logic [5:0] size_x, size_y, size_z;
  logic [SW-1:0] sx, sy, sz;

  logic       kind;
  logic [5:0] pos_x, pos_y, pos_z;
  logic [QUANTITIES-1:0][VALUE_BITS-1:0] wvals, rvals, rounded;

  logic [1:0][CW-1:0] cx, cy, cz;
  logic [2:0]         parity;
  logic signed [7:0]  lx, ly, lz;
  logic               write_ok;

  logic [2:0]    sel, mac_sel;
  logic [AW-1:0] addr;
  logic          ram_we, mac_en, out_load;
  logic          res_valid;
  result_word_t  res_data;

  function automatic logic [SW-1:0] eff_size(input logic [5:0] s);
    logic [SW-1:0] e;
    if (s == 6'd0) begin
      e = SW'(1);
    end else if (int'(s) > COARSE_DIM_MAX) begin
      e = SW'(COARSE_DIM_MAX);
    end else begin
      e = SW'(s);
    end
    return e;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic signed [7:0] c, input logic [SW-1:0] s);
    logic [CW-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (int'(c) > int'(s) - 1) begin
      r = CW'(int'(s) - 1);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  assign sx = eff_size(size_x);
  assign sy = eff_size(size_y);
  assign sz = eff_size(size_z);

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= 5'd2;
      origin_y <= 5'd2;
      origin_z <= 5'd2;
      size_x   <= 6'd32;
      size_y   <= 6'd32;
      size_z   <= 6'd32;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        REG_ZONE_ORIGIN_X: origin_x <= cfg.data.value[4:0];
        REG_ZONE_ORIGIN_Y: origin_y <= cfg.data.value[4:0];
        REG_ZONE_ORIGIN_Z: origin_z <= cfg.data.value[4:0];
        REG_COARSE_SIZE_X: size_x   <= cfg.data.value;
        REG_COARSE_SIZE_Y: size_y   <= cfg.data.value;
        REG_COARSE_SIZE_Z: size_z   <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // input word capture
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      kind     <= item.data.kind;
      pos_x    <= item.data.pos_x;
      pos_y    <= item.data.pos_y;
      pos_z    <= item.data.pos_z;
      wvals[0] <= VALUE_BITS'(item.data.density_in);
      wvals[1] <= VALUE_BITS'(item.data.velocity_x_in);
      wvals[2] <= VALUE_BITS'(item.data.velocity_y_in);
      wvals[3] <= VALUE_BITS'(item.data.velocity_z_in);
    end
  end

  // lower neighbor: origin + f/2, one less for even f
  assign lx = $signed({3'b000, origin_x}) + $signed({3'b000, pos_x[5:1]})
            - $signed({7'd0, ~pos_x[0]});
  assign ly = $signed({3'b000, origin_y}) + $signed({3'b000, pos_y[5:1]})
            - $signed({7'd0, ~pos_y[0]});
  assign lz = $signed({3'b000, origin_z}) + $signed({3'b000, pos_z[5:1]})
            - $signed({7'd0, ~pos_z[0]});

  assign write_ok = (int'(pos_x) < int'(sx)) && (int'(pos_y) < int'(sy))
                 && (int'(pos_z) < int'(sz));

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      parity <= {pos_z[0], pos_y[0], pos_x[0]};
      if (kind == KIND_INTERP) begin
        cx[0] <= clamp(lx, sx);
        cx[1] <= clamp(lx + 8'sd1, sx);
        cy[0] <= clamp(ly, sy);
        cy[1] <= clamp(ly + 8'sd1, sy);
        cz[0] <= clamp(lz, sz);
        cz[1] <= clamp(lz + 8'sd1, sz);
      end else begin
        cx[0] <= CW'(pos_x);
        cx[1] <= CW'(pos_x);
        cy[0] <= CW'(pos_y);
        cy[1] <= CW'(pos_y);
        cz[0] <= CW'(pos_z);
        cz[1] <= CW'(pos_z);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (kind == KIND_WRITE && !write_ok) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (kind == KIND_WRITE && step == STW'(WRITE_STEP)) begin
          state_next = S_IDLE;
        end else if (kind == KIND_INTERP && step == STW'(LAST_STEP)) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (!res_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        step <= '0;
      end else if (state == S_RUN) begin
        step <= step + STW'(1);
      end
    end
  end

  // neighbor n: bit 0 picks upper x, bit 1 upper y, bit 2 upper z
  assign sel = step[2:0];

  ctfti_addr #(.COARSE_DIM_MAX(COARSE_DIM_MAX)) u_addr (
    .clk  (clk),
    .x    (cx[sel[0]]),
    .y    (cy[sel[1]]),
    .z    (cz[sel[2]]),
    .sx   (sx),
    .sy   (sy),
    .addr (addr)
  );

  assign ram_we = (state == S_RUN) && (kind == KIND_WRITE) && (step == STW'(WRITE_STEP));

  for (genvar q = 0; q < QUANTITIES; q++) begin : g_ram
    ctfti_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .addr  (addr),
      .wdata (wvals[q]),
      .rdata (rvals[q])
    );
  end

  assign mac_en  = (state == S_RUN) && (kind == KIND_INTERP) && (step >= STW'(READ_LAT));
  assign mac_sel = 3'(step - STW'(READ_LAT));

  ctfti_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
    .clk     (clk),
    .clear   (state == S_PREP),
    .en      (mac_en),
    .weight  (neighbor_weight(mac_sel ^ parity)),
    .rdata   (rvals),
    .rounded (rounded)
  );

  // output register
  assign out_load = (state == S_ROUND) && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_data.density_out    <= 32'($signed(rounded[0]));
      res_data.velocity_x_out <= 32'($signed(rounded[1]));
      res_data.velocity_y_out <= 32'($signed(rounded[2]));
      res_data.velocity_z_out <= 32'($signed(rounded[3]));
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;
endmodule

### design/ctfti_checker.sv
`include "assert_macros.svh"

module ctfti_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_ready,
  input logic                    item_kind,
  input logic                    result_valid,
  input logic                    result_ready,
  input ctfti_pkg::result_word_t result_data
);
  import ctfti_pkg::*;

  `ASSERT_NR(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result_data), "result word dropped or changed while stalled")
  `ASSERT_NR(a_busy_after_accept, clk, rst, item_valid && item_ready |=> !item_ready, "input taken again right after a word")
  `ASSERT_NR(a_write_silent, clk, rst, item_valid && item_ready && item_kind == KIND_WRITE && !result_valid |=> !result_valid, "write word produced a result")
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result valid after reset")
endmodule

bind coarse_to_fine_trilinear_interp ctfti_checker u_ctfti_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_kind    (item.data.kind),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

### verif/coarse_to_fine_trilinear_interp_test.sv
`timescale 1ns / 1ps

module coarse_to_fine_trilinear_interp_test;
  import ctfti_pkg::*;

  localparam int CELLS = 32768;
  localparam int GRID_MAX = 32;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int SETTLE_CYCLES = 20;
  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER [6] = '{
    REG_ZONE_ORIGIN_X, REG_ZONE_ORIGIN_Y, REG_ZONE_ORIGIN_Z,
    REG_COARSE_SIZE_X, REG_COARSE_SIZE_Y, REG_COARSE_SIZE_Z
  };
  // origin x/y/z, size x/y/z as written; later phases are random
  localparam logic [5:0] PHASE_REGS [5][6] = '{
    '{6'd0,  6'd0,  6'd0,  6'd32, 6'd32, 6'd32},
    '{6'd63, 6'd63, 6'd63, 6'd63, 6'd33, 6'd0},
    '{6'd1,  6'd3,  6'd5,  6'd1,  6'd4,  6'd7},
    '{6'd2,  6'd2,  6'd2,  6'd5,  6'd3,  6'd32},
    '{6'd30, 6'd0,  6'd16, 6'd2,  6'd2,  6'd2}
  };

  typedef struct {
    item_word_t   word;
    bit           has_known;
    result_word_t known;
  } step_t;

  logic clk;
  logic rst;

  ctfti_chan #(.word_t(item_word_t))   item_if ();
  ctfti_chan #(.word_t(result_word_t)) result_if ();
  ctfti_chan #(.word_t(cfg_word_t))    cfg_if ();

  coarse_to_fine_trilinear_interp u_dut (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  logic [4:0]   zone_origin [3] = '{5'd2, 5'd2, 5'd2};
  logic [5:0]   grid_size [3] = '{6'd32, 6'd32, 6'd32};
  result_word_t cell_value [CELLS];
  bit           cell_written [CELLS];
  result_word_t interp_due [$];
  int           items_taken = 0;
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           burst = 1'b1;
  longint       cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(int axis);
    int s;
    s = grid_size[axis];
    if (s == 0) return 1;
    if (s > GRID_MAX) return GRID_MAX;
    return s;
  endfunction

  function automatic int neighbor(int axis, int p, int off);
    int c;
    int lim;
    c = int'(zone_origin[axis]) + (p >> 1) - ((p % 2) ? 0 : 1) + off;
    lim = eff_size(axis) - 1;
    if (c < 0) return 0;
    if (c > lim) return lim;
    return c;
  endfunction

  function automatic int axis_weight(int p, int off);
    if (p % 2) return off ? 1 : 3;
    return off ? 3 : 1;
  endfunction

  function automatic int cell_addr(int cx, int cy, int cz);
    return cx + (cy + cz * eff_size(1)) * eff_size(0);
  endfunction

  function automatic result_word_t interp_at(item_word_t w);
    longint acc [4];
    int p [3];
    int a;
    int wt;
    result_word_t r;
    p = '{int'(w.pos_x), int'(w.pos_y), int'(w.pos_z)};
    acc = '{default: 0};
    for (int k = 0; k < 2; k++)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++) begin
          a = cell_addr(neighbor(0, p[0], i), neighbor(1, p[1], j), neighbor(2, p[2], k));
          wt = axis_weight(p[0], i) * axis_weight(p[1], j) * axis_weight(p[2], k);
          acc[0] += wt * longint'(cell_value[a].density_out);
          acc[1] += wt * longint'(cell_value[a].velocity_x_out);
          acc[2] += wt * longint'(cell_value[a].velocity_y_out);
          acc[3] += wt * longint'(cell_value[a].velocity_z_out);
        end
    // round half up, floor on negatives
    r.density_out    = 32'((acc[0] + 32) >>> 6);
    r.velocity_x_out = 32'((acc[1] + 32) >>> 6);
    r.velocity_y_out = 32'((acc[2] + 32) >>> 6);
    r.velocity_z_out = 32'((acc[3] + 32) >>> 6);
    return r;
  endfunction

  function automatic void absorb_item(item_word_t w, bit has_known, result_word_t known);
    int a;
    if (w.kind == KIND_INTERP) begin
      interp_due.insert(interp_due.size(), has_known ? known : interp_at(w));
    end else if (w.pos_x < eff_size(0) && w.pos_y < eff_size(1) && w.pos_z < eff_size(2)) begin
      a = cell_addr(w.pos_x, w.pos_y, w.pos_z);
      cell_value[a] = '{w.density_in, w.velocity_x_in, w.velocity_y_in, w.velocity_z_in};
      cell_written[a] = 1'b1;
    end
    items_taken++;
  endfunction

  function automatic void apply_reg(cfg_word_t c);
    case (c.index)
      REG_ZONE_ORIGIN_X: zone_origin[0] = c.value[4:0];
      REG_ZONE_ORIGIN_Y: zone_origin[1] = c.value[4:0];
      REG_ZONE_ORIGIN_Z: zone_origin[2] = c.value[4:0];
      REG_COARSE_SIZE_X: grid_size[0] = c.value;
      REG_COARSE_SIZE_Y: grid_size[1] = c.value;
      REG_COARSE_SIZE_Z: grid_size[2] = c.value;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_word_t word_of(logic kind, int x, int y, int z,
                                         logic [31:0] d, logic [31:0] vx,
                                         logic [31:0] vy, logic [31:0] vz);
    item_word_t w;
    w.kind = kind;
    w.pos_x = 6'(x);
    w.pos_y = 6'(y);
    w.pos_z = 6'(z);
    w.density_in = d;
    w.velocity_x_in = vx;
    w.velocity_y_in = vy;
    w.velocity_z_in = vz;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_item(item_word_t w, bit has_known = 1'b0, result_word_t known = '0);
    @(negedge clk);
    while (!burst && $urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= w;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    absorb_item(w, has_known, known);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (interp_due.size() != 0) @(posedge clk);
  endtask

  // writes leave no result behind, so give the last one time to retire
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [5:0] vals [6], logic [CFG_INDEX_BITS-1:0] spare);
    cfg_word_t c;
    for (int r = 0; r < 7; r++) begin
      if (r == 0) begin
        c.index = spare;
        c.value = 6'($urandom);
      end else begin
        c.index = REG_ORDER[r-1];
        c.value = vals[r-1];
      end
      @(negedge clk);
      cfg_if.valid <= 1'b1;
      cfg_if.data <= c;
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      apply_reg(c);
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // fill any unwritten neighbor first so no read hits an empty cell
  task automatic run_interp(int px, int py, int pz);
    int a;
    int cx;
    int cy;
    int cz;
    for (int k = 0; k < 2; k++)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++) begin
          cx = neighbor(0, px, i);
          cy = neighbor(1, py, j);
          cz = neighbor(2, pz, k);
          a = cell_addr(cx, cy, cz);
          if (!cell_written[a])
            push_item(word_of(KIND_WRITE, cx, cy, cz, random_value(), random_value(),
                              random_value(), random_value()));
        end
    push_item(word_of(KIND_INTERP, px, py, pz, $urandom, $urandom, $urandom, $urandom));
  endtask

  always @(negedge clk) begin
    result_if.ready <= burst || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_results
    result_word_t want;
    result_word_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (interp_due.size() == 0) begin
        $error("result word with no interpolation pending: %h", got);
        fail_count++;
      end else begin
        want = interp_due.pop_front();
        check_field("density_out", want.density_out, got.density_out);
        check_field("velocity_x_out", want.velocity_x_out, got.velocity_x_out);
        check_field("velocity_y_out", want.velocity_y_out, got.velocity_y_out);
        check_field("velocity_z_out", want.velocity_z_out, got.velocity_z_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    step_t plan [$];
    logic [5:0] regs [6];
    int base [3];
    int pos [3];
    int goal;
    int n;
    int roll;
    int ax;

    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    result_if.ready = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset config: origin 2, size 32
    for (int c = 0; c < 8; c++)
      plan.insert(plan.size(), '{word_of(KIND_WRITE, 1 + c[0], 1 + c[1], 1 + c[2],
                                         32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                         32'hFFFF_FFFF), 1'b0, '0});
    plan.insert(plan.size(), '{word_of(KIND_INTERP, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0),
                               1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF}});
    // far corner clamps all eight neighbors onto one cell
    plan.insert(plan.size(), '{word_of(KIND_WRITE, 31, 31, 31, 32'h0100_0000, 32'hFF00_0000,
                                       32'h0080_0000, 32'h8000_0000), 1'b0, '0});
    plan.insert(plan.size(), '{word_of(KIND_INTERP, 63, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                               '{32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 32'h8000_0000}});
    // outside the grid: dropped
    plan.insert(plan.size(), '{word_of(KIND_WRITE, 40, 1, 1, 32'h1, 32'h2, 32'h3, 32'h4),
                               1'b0, '0});
    plan.insert(plan.size(), '{word_of(KIND_WRITE, 2, 2, 2, 32'h0, 32'h7FFF_FFFF,
                                       32'h1234_5678, 32'h8000_0001), 1'b0, '0});
    plan.insert(plan.size(), '{word_of(KIND_INTERP, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0),
                               1'b0, '0});
    for (int c = 0; c < 4; c++)
      plan.insert(plan.size(), '{word_of(KIND_WRITE, 3, 1 + c[0], 1 + c[1], 32'(-37 - c),
                                         32'(5 + 7 * c), 32'(-100 + c), 32'(63 * c - 1)),
                                 1'b0, '0});
    plan.insert(plan.size(), '{word_of(KIND_INTERP, 1, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0),
                               1'b0, '0});

    burst = 1'b1;
    foreach (plan[s]) push_item(plan[s].word, plan[s].has_known, plan[s].known);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      for (int r = 0; r < 6; r++) begin
        if (ph < 5) regs[r] = PHASE_REGS[ph][r];
        else if (r < 3) regs[r] = 6'($urandom_range(0, 63));
        else if ($urandom_range(0, 3) == 0) regs[r] = 6'($urandom_range(0, 63));
        else regs[r] = 6'($urandom_range(1, 8));
      end
      program_regs(regs, ph[0] ? REG_SPARE_B : REG_SPARE_A);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int a = 0; a < 3; a++) base[a] = $urandom_range(0, 56);

      goal = items_taken + ITEMS_PER_PHASE;
      n = 0;
      while (items_taken < goal) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        n++;
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
          hold_until_drained();
        end else if (roll < 61) begin
          for (int a = 0; a < 3; a++)
            pos[a] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63)
                                                : base[a] + $urandom_range(0, 7);
          run_interp(pos[0], pos[1], pos[2]);
        end else if (roll < 86) begin
          push_item(word_of(KIND_WRITE, $urandom_range(0, eff_size(0) - 1),
                            $urandom_range(0, eff_size(1) - 1),
                            $urandom_range(0, eff_size(2) - 1), random_value(),
                            random_value(), random_value(), random_value()));
        end else begin
          for (int a = 0; a < 3; a++) pos[a] = $urandom_range(0, 63);
          ax = $urandom_range(0, 2);
          pos[ax] = $urandom_range(eff_size(ax), 63);
          push_item(word_of(KIND_WRITE, pos[0], pos[1], pos[2], random_value(),
                            random_value(), random_value(), random_value()));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
